[src/fox_wolfram_moment_accumulator_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the moment accumulator RTL.
// ----------------------------------------------------------------------------
`ifndef FOX_WOLFRAM_MOMENT_ACCUMULATOR_ASSERT_SVH
`define FOX_WOLFRAM_MOMENT_ACCUMULATOR_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define FWMA_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define FWMA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/fwma_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fwma_pkg
// Widths, constants and the work-item type shared by the accumulator modules.
// ----------------------------------------------------------------------------
package fwma_pkg;

  localparam int NUM_MOMENTS = 11;
  localparam int ORD_W       = 4;
  localparam int ENERGY_W    = 16;
  localparam int EPROD_W     = 32;
  localparam int COS_W       = 16;
  localparam int P_W         = 32;
  localparam int CPROD_W     = 48;
  localparam int T_W         = 35;
  localparam int NUM_W       = 42;
  localparam int DIV_W       = 36;
  localparam int DIV_STEP    = 6;
  localparam int DIV_CYCLES  = DIV_W / DIV_STEP;
  localparam int DCNT_W      = 3;
  localparam int SUM_W       = 64;
  localparam int TERM_W      = 35;
  localparam int NORM_W      = 32;
  localparam int OUT_W       = 48;
  localparam int Q_W         = 49;

  localparam logic [NORM_W-1:0]       NORM_RESET = 32'd2065524;
  localparam logic signed [COS_W-1:0] COS_MAX    = 16'sd16384;
  localparam logic signed [COS_W-1:0] COS_MIN    = -16'sd16384;
  localparam logic signed [P_W-1:0]   P_ONE      = 32'sh4000_0000;

  localparam logic [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
  localparam logic [Q_W-1:0]   Q_POS_MAX = {2'b00, {(OUT_W-1){1'b1}}};
  localparam logic [Q_W-1:0]   Q_NEG_MAG = {2'b01, {(OUT_W-1){1'b0}}};

  typedef struct packed {
    logic [ORD_W-1:0]      order;
    logic signed [P_W-1:0] poly;
    logic [EPROD_W-1:0]    energy;
    logic                  last;
  } fwma_op_t;

endpackage
`default_nettype wire

[src/fwma_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fwma_front
// Takes a pair beat, clamps the cosine and runs the Legendre recurrence one
// order at a time, issuing one accumulate op per order.
// ----------------------------------------------------------------------------
module fwma_front import fwma_pkg::*; #(
  parameter int MAX_ORDER = 10
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic [ENERGY_W-1:0]     in_energy_first,
  input  wire logic [ENERGY_W-1:0]     in_energy_second,
  input  wire logic signed [COS_W-1:0] in_cos_angle,
  input  wire logic                    in_last_pair,
  output logic                         op_valid,
  input  wire logic                    op_ready,
  output fwma_op_t                     op
);

  typedef enum logic [4:0] {
    F_IDLE = 5'b00001,
    F_EMIT = 5'b00010,
    F_MUL  = 5'b00100,
    F_NUM  = 5'b01000,
    F_DIV  = 5'b10000
  } front_state_t;

  front_state_t              state_r, state_nxt;
  logic signed [COS_W-1:0]   c_r, c_clamp;
  logic [EPROD_W-1:0]        energy_r;
  logic                      last_r;
  logic [ORD_W-1:0]          n_r;
  logic signed [P_W-1:0]     p_hi_r, p_lo_r, p_new;
  logic signed [CPROD_W-1:0] prod_r;
  logic                      neg_r;
  logic [DIV_W-1:0]          dq_r, dq;
  logic [ORD_W-1:0]          rem_r, divisor, half;
  logic [DCNT_W-1:0]         dcnt_r;
  logic [CPROD_W:0]          prod_rnd;
  logic signed [T_W-1:0]     t;
  logic signed [5:0]         coef_a;
  logic signed [4:0]         coef_b;
  logic signed [NUM_W-1:0]   num;
  logic [NUM_W-1:0]          mag, mag_plus;
  logic [ORD_W:0]            r;
  logic                      accept, push, at_top, div_done;

  assign in_stall = (state_r != F_IDLE);
  assign accept   = in_valid && !in_stall;
  assign op_valid = (state_r == F_EMIT);
  assign push     = op_valid && op_ready;
  assign at_top   = (n_r == ORD_W'(MAX_ORDER));
  assign div_done = (dcnt_r == DCNT_W'(DIV_CYCLES - 1));

  always_comb begin
    op.order  = n_r;
    op.poly   = p_hi_r;
    op.energy = energy_r;
    op.last   = last_r && at_top;
  end

  always_comb begin
    priority if (in_cos_angle > COS_MAX) begin
      c_clamp = COS_MAX;
    end else if (in_cos_angle < COS_MIN) begin
      c_clamp = COS_MIN;
    end else begin
      c_clamp = in_cos_angle;
    end
  end

  // t = floor((c * Pn + 2^13) / 2^14), num = (2n+1) t - n P(n-1)
  always_comb begin
    prod_rnd = (CPROD_W + 1)'(prod_r) + (CPROD_W + 1)'(14'd8192);
    t        = prod_rnd[CPROD_W:CPROD_W-T_W+1];
    coef_a   = {1'b0, n_r, 1'b1};
    coef_b   = {1'b0, n_r};
    num      = NUM_W'(coef_a) * NUM_W'(t) - NUM_W'(coef_b) * NUM_W'(p_lo_r);
    mag      = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
    divisor  = n_r + ORD_W'(1);
    half     = divisor >> 1;
    mag_plus = mag + NUM_W'(half);
  end

  // six restoring-division digits per cycle by the small divisor n+1
  always_comb begin
    r  = {1'b0, rem_r};
    dq = dq_r;
    for (int i = 0; i < DIV_STEP; i++) begin
      r  = {r[ORD_W-1:0], dq[DIV_W-1]};
      dq = {dq[DIV_W-2:0], 1'b0};
      if (r >= {1'b0, divisor}) begin
        r     = r - {1'b0, divisor};
        dq[0] = 1'b1;
      end
    end
    p_new = neg_r ? -$signed(dq[P_W-1:0]) : $signed(dq[P_W-1:0]);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      F_IDLE: if (accept) state_nxt = F_EMIT;
      F_EMIT: begin
        if (push) begin
          priority if (at_top) begin
            state_nxt = F_IDLE;
          end else if (n_r == '0) begin
            state_nxt = F_EMIT;
          end else begin
            state_nxt = F_MUL;
          end
        end
      end
      F_MUL:  state_nxt = F_NUM;
      F_NUM:  state_nxt = F_DIV;
      F_DIV:  if (div_done) state_nxt = F_EMIT;
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      F_IDLE: begin
        if (accept) begin
          c_r      <= c_clamp;
          energy_r <= EPROD_W'(in_energy_first) * EPROD_W'(in_energy_second);
          last_r   <= in_last_pair;
          n_r      <= '0;
          p_hi_r   <= P_ONE;
        end
      end
      F_EMIT: begin
        if (push && !at_top && n_r == '0) begin
          p_lo_r <= p_hi_r;
          p_hi_r <= $signed({c_r, 16'h0000});
          n_r    <= ORD_W'(1);
        end
      end
      F_MUL: prod_r <= CPROD_W'(c_r) * CPROD_W'(p_hi_r);
      F_NUM: begin
        neg_r  <= num[NUM_W-1];
        dq_r   <= mag_plus[DIV_W-1:0];
        rem_r  <= '0;
        dcnt_r <= '0;
      end
      F_DIV: begin
        dq_r   <= dq;
        rem_r  <= r[ORD_W-1:0];
        dcnt_r <= dcnt_r + DCNT_W'(1);
        if (div_done) begin
          p_lo_r <= p_hi_r;
          p_hi_r <= p_new;
          n_r    <= n_r + ORD_W'(1);
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

[src/fwma_fifo.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fwma_fifo
// Short op queue between the recurrence front and the accumulate back.
// ----------------------------------------------------------------------------
`include "fox_wolfram_moment_accumulator_assert.svh"
module fwma_fifo import fwma_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      push_valid,
  output logic           push_ready,
  input  wire fwma_op_t  push_data,
  output logic           pop_valid,
  input  wire logic      pop_ready,
  output fwma_op_t       pop_data
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  fwma_op_t          mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              push, pop;

  assign push_ready = (cnt_r != CNT_W'(DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      unique case ({push, pop})
        2'b10:   cnt_r <= cnt_r + CNT_W'(1);
        2'b01:   cnt_r <= cnt_r - CNT_W'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  `FWMA_ASSERT_IMPL(a_fifo_bound, 1'b1, cnt_r <= CNT_W'(DEPTH), "op queue count over depth")
  `FWMA_ASSERT_NEXT(a_fifo_fill, push && !pop, cnt_r == $past(cnt_r) + CNT_W'(1), "op queue count did not advance")

endmodule
`default_nettype wire

[src/fwma_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fwma_back
// Multiplies energy by the polynomial value, adds into saturating sums, and
// on the last pair scales every sum into the result register.
// ----------------------------------------------------------------------------
`include "fox_wolfram_moment_accumulator_assert.svh"
module fwma_back import fwma_pkg::*; #(
  parameter int MAX_ORDER = 10
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       op_valid,
  output logic                            op_ready,
  input  wire fwma_op_t                   op,
  input  wire logic [NORM_W-1:0]          norm_factor,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic [NUM_MOMENTS-1:0][OUT_W-1:0] moments
);

  typedef enum logic [3:0] {
    B_ACCUM = 4'b0001,
    B_WAIT  = 4'b0010,
    B_SCAN  = 4'b0100,
    B_DRAIN = 4'b1000
  } back_state_t;

  back_state_t                        state_r, state_nxt;
  logic [NUM_MOMENTS-1:0][SUM_W-1:0]  sums_r;
  logic [NUM_MOMENTS-1:0][OUT_W-1:0]  moments_r;
  logic [ORD_W-1:0]                   k_r, rd_addr;
  logic                               s1_valid_r, s1_last_r;
  logic [ORD_W-1:0]                   s1_ord_r;
  logic signed [SUM_W-1:0]            s1_prod_r;
  logic                               s2_valid_r, s2_last_r;
  logic [ORD_W-1:0]                   s2_ord_r;
  logic signed [TERM_W-1:0]           term_r;
  logic                               sa_valid_r, sa_neg_r;
  logic [ORD_W-1:0]                   sa_idx_r;
  logic [SUM_W-1:0]                   sa_mag_r;
  logic                               sb_valid_r, sb_neg_r;
  logic [ORD_W-1:0]                   sb_idx_r;
  logic [SUM_W-1:0]                   sb_a_r, sb_b_r;
  logic                               out_valid_r;
  logic [SUM_W:0]                     prod_rnd, sum_ext, b_rnd;
  logic signed [SUM_W-1:0]            sum_rd;
  logic [SUM_W-1:0]                   sum_sat;
  logic [Q_W-1:0]                     q;
  logic                               a_big;
  logic [OUT_W-1:0]                   res;
  logic                               pop, scan_end, out_take;

  assign op_ready  = (state_r == B_ACCUM) && !(s1_valid_r && s1_last_r)
                     && !(s2_valid_r && s2_last_r);
  assign pop       = op_valid && op_ready;
  assign out_valid = out_valid_r;
  assign out_take  = out_valid_r && !out_stall;
  assign scan_end  = sb_valid_r && (sb_idx_r == ORD_W'(MAX_ORDER));
  assign rd_addr   = (state_r == B_SCAN) ? k_r : s2_ord_r;

  for (genvar l = 0; l < NUM_MOMENTS; l++) begin : g_out
    if (l <= MAX_ORDER) begin : g_used
      assign moments[l] = moments_r[l];
    end else begin : g_zero
      assign moments[l] = '0;
    end
  end

  always_comb begin
    prod_rnd = (SUM_W + 1)'(s1_prod_r) + (SUM_W + 1)'(30'h2000_0000);
    sum_rd   = $signed(sums_r[rd_addr]);
    sum_ext  = (SUM_W + 1)'(sum_rd) + (SUM_W + 1)'(term_r);
    if (sum_ext[SUM_W] != sum_ext[SUM_W-1]) begin
      sum_sat = sum_ext[SUM_W] ? SUM_MIN : SUM_MAX;
    end else begin
      sum_sat = sum_ext[SUM_W-1:0];
    end
  end

  // q = a * 2^14 + round(b / 2^18), clamp magnitude, then apply sign
  always_comb begin
    a_big = (sb_a_r[SUM_W-1:34] != '0);
    b_rnd = (SUM_W + 1)'(sb_b_r) + (SUM_W + 1)'(18'h2_0000);
    q     = Q_W'({sb_a_r[33:0], 14'h0000}) + Q_W'(b_rnd[SUM_W:18]);
    if (sb_neg_r) begin
      if (a_big || q > Q_NEG_MAG) q = Q_NEG_MAG;
      res = OUT_W'(0) - q[OUT_W-1:0];
    end else begin
      if (a_big || q > Q_POS_MAX) q = Q_POS_MAX;
      res = q[OUT_W-1:0];
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_ACCUM: if (s2_valid_r && s2_last_r) state_nxt = B_WAIT;
      B_WAIT:  if (!out_valid_r) state_nxt = B_SCAN;
      B_SCAN:  if (k_r == ORD_W'(MAX_ORDER)) state_nxt = B_DRAIN;
      B_DRAIN: if (scan_end) state_nxt = B_ACCUM;
      default: state_nxt = B_ACCUM;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_ACCUM;
      k_r         <= '0;
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      sa_valid_r  <= 1'b0;
      sb_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      sums_r      <= '0;
    end else begin
      state_r    <= state_nxt;
      s1_valid_r <= pop;
      s2_valid_r <= s1_valid_r;
      sa_valid_r <= (state_r == B_SCAN);
      sb_valid_r <= sa_valid_r;
      if (state_r == B_WAIT) begin
        k_r <= '0;
      end else if (state_r == B_SCAN) begin
        k_r <= k_r + ORD_W'(1);
      end
      priority if (state_r == B_SCAN) begin
        sums_r[k_r] <= '0;
      end else if (s2_valid_r) begin
        sums_r[s2_ord_r] <= sum_sat;
      end
      priority if (scan_end) begin
        out_valid_r <= 1'b1;
      end else if (out_take) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_last_r <= op.last;
    s1_ord_r  <= op.order;
    s1_prod_r <= SUM_W'($signed({1'b0, op.energy})) * SUM_W'(op.poly);
    s2_last_r <= s1_last_r;
    s2_ord_r  <= s1_ord_r;
    term_r    <= prod_rnd[SUM_W:30];
    sa_idx_r  <= k_r;
    sa_neg_r  <= sum_rd[SUM_W-1];
    sa_mag_r  <= sum_rd[SUM_W-1] ? SUM_W'(0) - sum_rd : sum_rd;
    sb_idx_r  <= sa_idx_r;
    sb_neg_r  <= sa_neg_r;
    sb_a_r    <= sa_mag_r[SUM_W-1:32] * norm_factor;
    sb_b_r    <= sa_mag_r[31:0] * norm_factor;
    if (sb_valid_r) begin
      moments_r[sb_idx_r] <= res;
    end
  end

  `FWMA_ASSERT_IMPL(a_scan_idle_pipe, state_r == B_SCAN, !s1_valid_r && !s2_valid_r, "scan with ops in flight")
  `FWMA_ASSERT_IMPL(a_result_hold, sb_valid_r, !out_valid_r, "result register overwritten while pending")
  `FWMA_ASSERT_IMPL(a_result_rise, $rose(out_valid_r), $past(sb_valid_r) && $past(sb_idx_r) == ORD_W'(MAX_ORDER), "result raised before scan end")

endmodule
`default_nettype wire

[src/fox_wolfram_moment_accumulator.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fox_wolfram_moment_accumulator
// Accumulates energy-weighted Legendre moments of particle pairs and emits
// the normalized moments on the last pair of each event.
//
//   port group   dir  handshake          payload
//   in_*         in   in_valid/in_stall  two energies, cosine, last marker
//   out_*        out  out_valid/out_stall eleven 48-bit moments
//   cfg_*        in   cfg_wr_en          norm_factor
//
// In the front a pair is accepted and emits orders zero and one; each later
// recurrence step then runs multiply, combine, iterated divide and emit.
// For the last pair, out_valid rises once its ops have passed the queue,
// the accumulate pipe and the scaling scan.
// Synchronous reset clears the sums and the handshake state.
// The op queue lets the front take the next pair while a result is pending.
// ----------------------------------------------------------------------------
module fox_wolfram_moment_accumulator import fwma_pkg::*; #(
  parameter int MAX_ORDER  = 10,
  parameter int FIFO_DEPTH = 4
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic [ENERGY_W-1:0]     in_energy_first,
  input  wire logic [ENERGY_W-1:0]     in_energy_second,
  input  wire logic signed [COS_W-1:0] in_cos_angle,
  input  wire logic                    in_last_pair,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic signed [OUT_W-1:0]      out_moment_0,
  output logic signed [OUT_W-1:0]      out_moment_1,
  output logic signed [OUT_W-1:0]      out_moment_2,
  output logic signed [OUT_W-1:0]      out_moment_3,
  output logic signed [OUT_W-1:0]      out_moment_4,
  output logic signed [OUT_W-1:0]      out_moment_5,
  output logic signed [OUT_W-1:0]      out_moment_6,
  output logic signed [OUT_W-1:0]      out_moment_7,
  output logic signed [OUT_W-1:0]      out_moment_8,
  output logic signed [OUT_W-1:0]      out_moment_9,
  output logic signed [OUT_W-1:0]      out_moment_10,
  input  wire logic                    cfg_wr_en,
  input  wire logic [NORM_W-1:0]       cfg_wr_data
);

  logic [NORM_W-1:0]                 norm_r;
  logic                              f_valid, f_ready, b_valid, b_ready;
  fwma_op_t                          f_op, b_op;
  logic [NUM_MOMENTS-1:0][OUT_W-1:0] moments;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      norm_r <= NORM_RESET;
    end else if (cfg_wr_en) begin
      norm_r <= cfg_wr_data;
    end
  end

  fwma_front #(
    .MAX_ORDER (MAX_ORDER)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_energy_first  (in_energy_first),
    .in_energy_second (in_energy_second),
    .in_cos_angle     (in_cos_angle),
    .in_last_pair     (in_last_pair),
    .op_valid         (f_valid),
    .op_ready         (f_ready),
    .op               (f_op)
  );

  fwma_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (f_op),
    .pop_valid  (b_valid),
    .pop_ready  (b_ready),
    .pop_data   (b_op)
  );

  fwma_back #(
    .MAX_ORDER (MAX_ORDER)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .op_valid    (b_valid),
    .op_ready    (b_ready),
    .op          (b_op),
    .norm_factor (norm_r),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .moments     (moments)
  );

  assign out_moment_0  = $signed(moments[0]);
  assign out_moment_1  = $signed(moments[1]);
  assign out_moment_2  = $signed(moments[2]);
  assign out_moment_3  = $signed(moments[3]);
  assign out_moment_4  = $signed(moments[4]);
  assign out_moment_5  = $signed(moments[5]);
  assign out_moment_6  = $signed(moments[6]);
  assign out_moment_7  = $signed(moments[7]);
  assign out_moment_8  = $signed(moments[8]);
  assign out_moment_9  = $signed(moments[9]);
  assign out_moment_10 = $signed(moments[10]);

endmodule
`default_nettype wire
